@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define FUR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define FUR_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define FUR_ASSERT(lbl, clk, rst_n, prop, msg)
`define FUR_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ rtl/core/fur_pkg.sv @@
// shared types, constants and crc helper for the framed receiver
package fur_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int BYTE_W      = 8;
    localparam int OUT_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam int CRC_BITS_PER_CYCLE = 2;
    localparam int CRC_CYCLES = BYTE_W / CRC_BITS_PER_CYCLE;
    localparam int CRC_CNT_W  = $clog2(CRC_CYCLES);

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST   = LEN_W'(MAX_PAYLOAD);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 2'd2;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] seed;
    } crc_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] crc;
    } crc_rsp_t;

    // one msb-first shift of the crc register
    function automatic logic [BYTE_W-1:0] crc_bit_step(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] sh;
        sh = {c[BYTE_W-2:0], 1'b0};
        return c[BYTE_W-1] ? (sh ^ CRC_POLY) : sh;
    endfunction

endpackage

@@ rtl/core/fur_ram.sv @@
// generic single-port-write ram with registered read
module fur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/fur_crc8.sv @@
// shared crc-8 shift unit, two bits per cycle
module fur_crc8
    import fur_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  crc_req_t req,
    output crc_rsp_t rsp
);

    `include "assert_macros.svh"

    logic                 busy_reg, busy_next;
    logic [CRC_CNT_W-1:0] cnt_reg, cnt_next;
    logic [BYTE_W-1:0]    crc_reg, crc_next;
    logic [BYTE_W-1:0]    stepped;
    logic                 last_step;

    always_comb begin
        stepped = crc_reg;
        for (int k = 0; k < CRC_BITS_PER_CYCLE; k++) begin
            stepped = crc_bit_step(stepped);
        end
    end

    assign last_step = busy_reg && (cnt_reg == CRC_CNT_W'(CRC_CYCLES - 1));

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        crc_next  = crc_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            crc_next  = req.seed;
        end else if (busy_reg) begin
            crc_next = stepped;
            cnt_next = cnt_reg + 1'b1;
            if (last_step) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        crc_reg <= crc_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = last_step;
    assign rsp.crc  = stepped;

    `FUR_NEVER(a_start_while_busy, aclk, aresetn, req.start && busy_reg,
        "crc unit restarted while busy")
    `FUR_ASSERT(a_done_frees_unit, aclk, aresetn, last_step |=> !busy_reg,
        "crc unit still busy after done")
    `FUR_NEVER(a_idle_count_clear, aclk, aresetn, !busy_reg && (cnt_reg != '0),
        "crc step count not cleared while idle")

endmodule

@@ rtl/core/framed_uart_receiver_crc8.sv @@
// Framed receiver: start marker, length, payload with crc-8 byte, end marker.
// Marker and length bytes are taken directly; a non-final payload byte is
// accepted, then run through the shared crc shift unit at 2 bits per cycle.
// A good frame of L bytes is emitted one byte at a time from the payload ram
// (registered read, then output register held on stall), no input taken meanwhile.
// aresetn is synchronous: control state and config registers take reset values.
module framed_uart_receiver_crc8
    import fur_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // rx_byte [7:0]
    input  logic [BYTE_W-1:0]     s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // payload_byte [7:0], byte_index [13:8], frame_length [20:14], zero [23:21]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]     cfg_wdata
);

    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CRC  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_LOAD = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_PAY  = 4'b0100,
        PH_END  = 4'b1000
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [BYTE_W-1:0] start_marker_reg, end_marker_reg;
    logic [LEN_W-1:0]  max_length_reg;

    logic [LEN_W-1:0]  frame_len_reg, frame_len_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] emit_idx_reg, emit_idx_next;
    logic [BYTE_W-1:0] run_crc_reg, run_crc_next;
    logic [BYTE_W-1:0] rx_crc_reg, rx_crc_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic              in_acc;
    logic              out_free;
    logic [LEN_W-1:0]  len_limit;
    logic              len_bad;
    logic              pay_final;
    logic              emit_last;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;

    crc_req_t crc_req;
    crc_rsp_t crc_rsp;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign len_limit = (max_length_reg > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                              : max_length_reg;
    assign len_bad   = (s_tdata == '0) || (s_tdata > BYTE_W'(len_limit));
    assign pay_final = ({1'b0, idx_reg} + 1'b1) == frame_len_reg;
    assign emit_last = ({1'b0, emit_idx_reg} + 1'b1) == frame_len_reg;

    assign ram_we       = in_acc && (phase_reg == PH_PAY);
    assign crc_req.start = ram_we && !pay_final;
    assign crc_req.seed  = run_crc_reg ^ s_tdata;

    fur_crc8 u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (crc_req),
        .rsp     (crc_rsp)
    );

    fur_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (s_tdata),
        .raddr (emit_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        frame_len_next = frame_len_reg;
        idx_next       = idx_reg;
        emit_idx_next  = emit_idx_reg;
        run_crc_next   = run_crc_reg;
        rx_crc_next    = rx_crc_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (phase_reg)
                        PH_HUNT: begin
                            if (s_tdata == start_marker_reg) begin
                                phase_next   = PH_LEN;
                                run_crc_next = '0;
                                rx_crc_next  = '0;
                            end
                        end
                        PH_LEN: begin
                            if (len_bad) begin
                                phase_next = PH_HUNT;
                            end else begin
                                frame_len_next = s_tdata[LEN_W-1:0];
                                idx_next       = '0;
                                phase_next     = PH_PAY;
                            end
                        end
                        PH_PAY: begin
                            idx_next = idx_reg + 1'b1;
                            if (pay_final) begin
                                rx_crc_next = s_tdata;
                                phase_next  = PH_END;
                            end else begin
                                state_next = ST_CRC;
                            end
                        end
                        PH_END: begin
                            phase_next = PH_HUNT;
                            if (s_tdata == end_marker_reg && run_crc_reg == rx_crc_reg) begin
                                emit_idx_next = '0;
                                state_next    = ST_RD;
                            end
                        end
                        default: begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
            end
            ST_CRC: begin
                if (crc_rsp.done) begin
                    run_crc_next = crc_rsp.crc;
                    state_next   = ST_IDLE;
                end
            end
            ST_RD: begin
                // ram address is emit_idx, data shows up next cycle
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(OUT_DATA_W - BYTE_W - ADDR_W - LEN_W)'(0),
                                     frame_len_reg, emit_idx_reg, ram_rdata};
                    m_tlast_next  = emit_last;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                        state_next    = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_HUNT;
            frame_len_reg    <= '0;
            idx_reg          <= '0;
            emit_idx_reg     <= '0;
            run_crc_reg      <= '0;
            rx_crc_reg       <= '0;
            m_tvalid_reg     <= 1'b0;
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
            max_length_reg   <= MAX_LENGTH_RST;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            frame_len_reg <= frame_len_next;
            idx_reg      <= idx_next;
            emit_idx_reg <= emit_idx_next;
            run_crc_reg  <= run_crc_next;
            rx_crc_reg   <= rx_crc_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_MARKER: start_marker_reg <= cfg_wdata;
                    REG_END_MARKER:   end_marker_reg   <= cfg_wdata;
                    REG_MAX_LENGTH:   max_length_reg   <= cfg_wdata[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `FUR_ASSERT(a_last_matches_len, aclk, aresetn,
        (m_tvalid_reg && m_tlast_reg) |->
            ({1'b0, m_tdata_reg[BYTE_W +: ADDR_W]} + 1'b1)
                == m_tdata_reg[BYTE_W + ADDR_W +: LEN_W],
        "last flag not on final payload byte")
    `FUR_ASSERT(a_idle_crc_free, aclk, aresetn,
        (state_reg == ST_IDLE) |-> !crc_rsp.busy,
        "crc unit busy while taking requests")
    `FUR_ASSERT(a_crc_in_payload, aclk, aresetn,
        (state_reg == ST_CRC) |-> (phase_reg == PH_PAY || phase_reg == PH_END),
        "crc running outside payload")
    `FUR_ASSERT(a_len_in_range, aclk, aresetn,
        (phase_reg == PH_PAY || phase_reg == PH_END) |->
            (frame_len_reg != '0 && frame_len_reg <= LEN_W'(MAX_PAYLOAD)),
        "frame length out of range inside a frame")

endmodule

@@ dv/framed_uart_receiver_crc8_test.sv @@
// self-checking testbench for the framed receiver with crc-8 check
module framed_uart_receiver_crc8_test
    import fur_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] payload;
        logic [5:0] index;
        logic [6:0] flen;
        logic       last;
    } payload_beat_t;

    typedef struct {
        logic [7:0]    rx;
        bit            typed;
        bit            has_res;
        payload_beat_t beat;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [BYTE_W-1:0]     s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [BYTE_W-1:0]     cfg_wdata;

    framed_uart_receiver_crc8 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // deframer model state and register copy
    logic [7:0] cfg_start;
    logic [7:0] cfg_end;
    logic [6:0] cfg_max;
    int         pos;
    int         flen;
    logic [7:0] crc_run;
    logic [7:0] crc_rx;
    logic [7:0] store [64];

    payload_beat_t payload_due [$];
    payload_beat_t step_out [$];
    dir_row_t      dir_rows [$];

    bit            row_typed;
    bit            row_has;
    payload_beat_t row_beat;

    int  mismatches;
    int  cycles;
    int  bytes_sent;
    int  beats_seen;
    int  frames_seen;
    int  idle_odds;
    int  stall_left;
    bit  quiet;

    function automatic logic [7:0] crc8_next(logic [7:0] c, logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int k = 0; k < 8; k++)
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        return r;
    endfunction

    function automatic int length_cap();
        int lim;
        lim = cfg_max;
        if (lim > MAX_PAYLOAD) lim = MAX_PAYLOAD;
        if (lim > 64) lim = 64;
        return lim;
    endfunction

    // advance the model by one received byte, results go to step_out
    function automatic void deframe_byte(logic [7:0] b);
        int idx;
        step_out.delete();
        if (pos == 0) begin
            if (b == cfg_start) begin
                pos = 1;
                crc_run = 8'h00;
                crc_rx = 8'h00;
            end
        end else if (pos == 1) begin
            if (b == 0 || int'(b) > length_cap()) begin
                pos = 0;
            end else begin
                flen = b;
                pos = 2;
            end
        end else if (pos < flen + 2) begin
            idx = (pos - 2) & 63;
            store[idx] = b;
            if (idx + 1 < flen)
                crc_run = crc8_next(crc_run, b);
            else
                crc_rx = b;
            pos = (pos + 1) & 8'h7F;
        end else begin
            pos = 0;
            if (b == cfg_end && crc_run == crc_rx) begin
                for (int i = 0; i < flen; i++)
                    step_out.push_back(payload_beat_t'{store[i], 6'(i), 7'(flen),
                                                       (i + 1 == flen)});
            end
        end
    endfunction

    function automatic void add_row(logic [7:0] rx, bit typed = 0, bit has_res = 0,
                                    payload_beat_t beat = '0);
        dir_row_t r;
        r.rx = rx;
        r.typed = typed;
        r.has_res = has_res;
        r.beat = beat;
        dir_rows.push_back(r);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    endtask

    // one request on the input side, called and returning at a falling edge
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = 0;
        if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds)
            gap = $urandom_range(1, 8);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = b;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        deframe_byte(b);
        if (row_typed) begin
            if (row_has) payload_due.push_back(row_beat);
        end else begin
            foreach (step_out[i]) payload_due.push_back(step_out[i]);
        end
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (payload_due.size() != 0) @(posedge aclk);
        // a dropped frame raises no result, so give the crc unit time to settle
        repeat (16) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_START_MARKER: cfg_start = val;
            REG_END_MARKER:   cfg_end = val;
            REG_MAX_LENGTH:   cfg_max = val[6:0];
            default: ;
        endcase
    endtask

    task automatic send_frame(int len, bit bad_crc, bit bad_end);
        logic [7:0] c;
        logic [7:0] d;
        c = 8'h00;
        send_byte(cfg_start);
        send_byte(8'(len));
        for (int i = 0; i < len - 1; i++) begin
            case ($urandom_range(0, 9))
                0:       d = cfg_start;
                1:       d = cfg_end;
                default: d = 8'($urandom);
            endcase
            c = crc8_next(c, d);
            send_byte(d);
        end
        send_byte(bad_crc ? c ^ 8'($urandom_range(1, 255)) : c);
        send_byte(bad_end ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end);
    endtask

    task automatic random_frame();
        int lim;
        int kind;
        int len;
        int short_top;
        lim = length_cap();
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            // line noise between frames
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else if (kind == 8) begin
            send_byte(cfg_start);
            send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(lim + 1, 255)));
        end else begin
            short_top = (lim < 1) ? 6 : ((lim < 6) ? lim : 6);
            if (lim > 0 && $urandom_range(0, 7) == 0)
                len = $urandom_range(1, lim);
            else
                len = $urandom_range(1, short_top);
            send_frame(len, kind == 6, kind == 7);
        end
    endtask

    task automatic run_phase(int budget, bit pressure);
        int target;
        int n;
        target = bytes_sent + budget;
        n = 0;
        while (bytes_sent < target) begin
            random_frame();
            n++;
            if (pressure && n % 4 == 0) drain_results();
        end
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     payload_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        payload_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (payload_due.size() == 0) begin
                flag_mismatch("unexpected payload byte", m_tdata[7:0], 0);
            end else begin
                want = payload_due.pop_front();
                if (m_tdata[7:0] !== want.payload)
                    flag_mismatch("payload_byte", m_tdata[7:0], want.payload);
                if (m_tdata[13:8] !== want.index)
                    flag_mismatch("byte_index", m_tdata[13:8], want.index);
                if (m_tdata[20:14] !== want.flen)
                    flag_mismatch("frame_length", m_tdata[20:14], want.flen);
                if (m_tlast !== want.last)
                    flag_mismatch("last", m_tlast, want.last);
                beats_seen++;
                if (want.last) frames_seen++;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tdata = '0;
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        stall_left = 0;
        quiet = 1'b0;
        idle_odds = 25;
        mismatches = 0;
        cycles = 0;
        bytes_sent = 0;
        beats_seen = 0;
        frames_seen = 0;
        row_typed = 1'b0;
        row_has = 1'b0;
        row_beat = '0;

        cfg_start = START_MARKER_RST;
        cfg_end = END_MARKER_RST;
        cfg_max = MAX_LENGTH_RST;
        pos = 0;
        flen = 0;
        crc_run = 8'h00;
        crc_rx = 8'h00;
        foreach (store[i]) store[i] = 8'h00;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // length of one with a zero crc byte
        add_row(START_MARKER_RST);
        add_row(8'h01);
        add_row(8'h00);
        add_row(END_MARKER_RST, 1, 1, payload_beat_t'{8'h00, 6'd0, 7'd1, 1'b1});
        // zero length and one above the maximum
        add_row(START_MARKER_RST);
        add_row(8'h00, 1, 0);
        add_row(START_MARKER_RST);
        add_row(8'h41, 1, 0);
        // wrong end byte, then crc mismatch
        add_row(START_MARKER_RST);
        add_row(8'h01);
        add_row(8'h00);
        add_row(8'h54, 1, 0);
        add_row(START_MARKER_RST);
        add_row(8'h01);
        add_row(8'h01);
        add_row(END_MARKER_RST, 1, 0);
        // all ones data
        add_row(START_MARKER_RST);
        add_row(8'h02);
        add_row(8'hFF);
        add_row(8'hF3);
        add_row(END_MARKER_RST);
        // marker values carried as data
        add_row(START_MARKER_RST);
        add_row(8'h03);
        add_row(START_MARKER_RST);
        add_row(END_MARKER_RST);
        add_row(crc8_next(crc8_next(8'h00, START_MARKER_RST), END_MARKER_RST));
        add_row(END_MARKER_RST);

        foreach (dir_rows[i]) begin
            row_typed = dir_rows[i].typed;
            row_has = dir_rows[i].has_res;
            row_beat = dir_rows[i].beat;
            send_byte(dir_rows[i].rx);
        end
        row_typed = 1'b0;

        drain_results();
        write_reg(REG_START_MARKER, 8'h00);
        write_reg(REG_END_MARKER, 8'hFF);
        write_reg(REG_MAX_LENGTH, 8'd1);
        run_phase(20, 1'b0);

        drain_results();
        write_reg(REG_START_MARKER, 8'hFF);
        write_reg(REG_END_MARKER, 8'h00);
        write_reg(REG_MAX_LENGTH, 8'd64);
        run_phase(25, 1'b1);

        // max length of zero rejects everything; spare index must be ignored
        drain_results();
        write_reg(REG_SPARE, 8'($urandom));
        write_reg(REG_MAX_LENGTH, 8'd0);
        write_reg(REG_START_MARKER, 8'($urandom));
        write_reg(REG_END_MARKER, 8'($urandom));
        run_phase(12, 1'b0);

        // oversized max acts as 64
        drain_results();
        write_reg(REG_MAX_LENGTH, 8'hFF);
        send_byte(cfg_start);
        send_byte(8'd65);
        send_frame(64, 1'b0, 1'b0);
        run_phase(15, 1'b0);

        drain_results();
        write_reg(REG_START_MARKER, 8'($urandom));
        write_reg(REG_END_MARKER, 8'($urandom));
        write_reg(REG_MAX_LENGTH, 8'($urandom_range(2, 16)));
        run_phase(12, 1'b0);
        idle_odds = 0;
        run_phase(12, 1'b0);

        // closing stretch at full rate on both sides
        drain_results();
        quiet = 1'b1;
        write_reg(REG_START_MARKER, START_MARKER_RST);
        write_reg(REG_END_MARKER, END_MARKER_RST);
        write_reg(REG_MAX_LENGTH, 8'(MAX_LENGTH_RST));
        run_phase(20, 1'b0);

        s_tvalid = 1'b0;
        while (payload_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d bytes over seven register settings", bytes_sent);
        $display("checked %0d payload bytes in %0d accepted frames", beats_seen, frames_seen);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/fur_pkg.sv
rtl/core/fur_ram.sv
rtl/core/fur_crc8.sv
rtl/core/framed_uart_receiver_crc8.sv
dv/framed_uart_receiver_crc8_test.sv
